// ----- hw/rtl/sctg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctg_pkg
// Shared types, codes and constants of the station credit traffic gate.
// ----------------------------------------------------------------------------
package sctg_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int ADDR_W = 48;
	localparam int WORD_W = 32;
	localparam int KBPS_W = 23;
	localparam int RUN_W = 16;
	localparam int SLOT_FIELD_W = 5;
	localparam int BITS_PER_BYTE = 8;
	localparam int PER_KILO = 1000;

	localparam logic [3:0] ACT_ADD = 4'd0;
	localparam logic [3:0] ACT_REMOVE = 4'd1;
	localparam logic [3:0] ACT_SET_EN = 4'd2;
	localparam logic [3:0] ACT_SET_CREDIT = 4'd3;
	localparam logic [3:0] ACT_SET_LOCK = 4'd4;
	localparam logic [3:0] ACT_RX = 4'd5;
	localparam logic [3:0] ACT_TX = 4'd6;
	localparam logic [3:0] ACT_SEEN = 4'd7;
	localparam logic [3:0] ACT_TICK = 4'd8;
	localparam logic [3:0] ACT_QUERY_MAC = 4'd9;
	localparam logic [3:0] ACT_QUERY_SLOT = 4'd10;
	localparam logic [3:0] ACT_SET_RIDER = 4'd11;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_DUP = 2'd3;

	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	// One slot record as it is stored in the table memory.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              enabled;
		logic [WORD_W-1:0] credit;
		logic [WORD_W-1:0] rx;
		logic [WORD_W-1:0] tx;
		logic [KBPS_W-1:0] kbps;
		logic [RUN_W-1:0]  run;
		logic              paused;
		logic              locked;
		logic              seen;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_SCAN,
		SQ_TICK,
		SQ_SHIFT,
		SQ_FINISH,
		SQ_OUT
	} sq_state_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              found;
		logic [3:0]        slot_out;
		logic              allowed;
		logic [WORD_W-1:0] credit_out;
		logic [KBPS_W-1:0] throughput_out;
		logic              enabled_out;
		logic              paused_out;
		logic              locked_out;
		logic [4:0]        entry_count;
		logic [4:0]        rider_out;
		logic [1:0]        tick_flags;
	} result_t;

	// Tick update of one slot; returns the new record.
	function automatic slot_rec_t tick_slot(input slot_rec_t r, input logic [WORD_W-1:0] kb,
		input logic [WORD_W-1:0] thr, input logic [RUN_W-1:0] tmo);
		slot_rec_t n;
		n = r;
		n.rx = '0;
		n.tx = '0;
		n.seen = 1'b0;
		if (!r.seen) begin
			n.kbps = '0;
			n.run = '0;
			n.paused = 1'b1;
		end else begin
			n.kbps = kb[KBPS_W-1:0];
			if (kb > thr) begin
				n.run = '0;
				n.paused = 1'b0;
			end else begin
				if (r.run != {RUN_W{1'b1}}) begin
					n.run = r.run + 1'b1;
				end
				if (tmo == '0 || n.run >= tmo) begin
					n.paused = 1'b1;
				end
			end
			if (!n.paused && r.enabled && r.credit != '0 && !r.locked) begin
				n.credit = r.credit - 1'b1;
			end
		end
		return n;
	endfunction

endpackage

// ----- hw/rtl/sctg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctg_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sctg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/sctg_kbps.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctg_kbps
// Converts a byte delta to kbps: (delta * 8 mod 2^32) / 1000 by reciprocal.
// ----------------------------------------------------------------------------
module sctg_kbps
	import sctg_pkg::*;
(
	input  logic              clk,
	input  logic [WORD_W-1:0] rx,
	input  logic [WORD_W-1:0] tx,
	output logic [WORD_W-1:0] kbps
);
	// q = floor(bits / 1000) via multiply by ceil(2^41/1000) with a fix-up.
	localparam logic [WORD_W-1:0] RECIP = 32'd2199023256;
	logic [WORD_W-1:0] bits_s1;
	logic [63:0]       prod;
	logic [WORD_W-1:0] est;
	logic [WORD_W-1:0] rem;
	logic [WORD_W-1:0] bits_s2;
	logic [WORD_W-1:0] est_s2;

	assign prod = bits_s1 * RECIP;
	assign est = {9'd0, prod[63:41]};

	always_ff @(posedge clk) begin
		bits_s1 <= (rx + tx) << 3;
		bits_s2 <= bits_s1;
		est_s2 <= est;
	end

	always_comb begin
		rem = bits_s2 - est_s2 * WORD_W'(PER_KILO);
		if (rem >= WORD_W'(PER_KILO)) begin
			kbps = est_s2 + 1'b1;
		end else begin
			kbps = est_s2;
		end
	end
endmodule

// ----- hw/rtl/station_credit_traffic_gate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// station_credit_traffic_gate
// Station table with compacting slots, byte accounting and a tick-driven
// idle gate and credit counter, held in one slot memory.
// ----------------------------------------------------------------------------
// Channel    Dir  Fields
// s_axis     in   tdata: action, mac, slot, value
// m_axis     out  tdata: status .. tick_flags
// cfg        in   we, index, data
// An address lookup, a slot item, a remove and a tick each walk the slot
// memory one entry at a time through its single read port. Reset empties the
// table at once through the fill count; no clearing pass. A result waits in
// the output register while m_axis_tready is low, and no item is taken
// meanwhile.
// ----------------------------------------------------------------------------
module station_credit_traffic_gate
	import sctg_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// action[3:0], mac[51:4], slot[56:52], value[88:57], zeros up to 95
	input  logic [95:0]   s_axis_tdata,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// status[1:0], found[2], slot_out[6:3], allowed[7], credit_out[39:8],
	// throughput_out[62:40], enabled_out[63], paused_out[64], locked_out[65],
	// entry_count[70:66], rider_out[75:71], tick_flags[77:76], zeros to 79
	output logic [79:0]   m_axis_tdata,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data
);
	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);

	logic [WORD_W-1:0] thr_q;
	logic [RUN_W-1:0]  tmo_q;

	sq_state_t state_q, state_d;
	logic [3:0]        act_q;
	logic [ADDR_W-1:0] mac_q;
	logic [4:0]        sl_q;
	logic [WORD_W-1:0] val_q;
	logic [CW-1:0]     used_q;
	logic [4:0]        rider_q;
	logic [CW-1:0]     idx_q;
	logic [1:0]        ph_q;
	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	logic [1:0]        flags_q;
	result_t           res_q;
	logic              ovalid_q;

	logic              we;
	logic [IW-1:0]     waddr, raddr;
	slot_rec_t         wrec, rrec;
	logic [REC_W-1:0]  rdata;
	logic [WORD_W-1:0] kb;
	logic              slot_ok;
	result_t           fin_res;

	assign rrec = slot_rec_t'(rdata);

	sctg_ram #(.WIDTH(REC_W), .DEPTH(NUM_SLOTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wrec),
		.raddr(raddr), .rdata(rdata)
	);

	sctg_kbps u_kbps (.clk(clk), .rx(rrec.rx), .tx(rrec.tx), .kbps(kb));

	assign s_axis_tready = (state_q == SQ_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {2'd0, res_q.tick_flags, res_q.rider_out, res_q.entry_count,
		res_q.locked_out, res_q.paused_out, res_q.enabled_out, res_q.throughput_out,
		res_q.credit_out, res_q.allowed, res_q.slot_out, res_q.found, res_q.status};
	assign slot_ok = ({1'b0, sl_q} < 6'(used_q)) && (32'(sl_q) < NUM_SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			tmo_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_THRESHOLD) begin
				thr_q <= cfg_data;
			end else begin
				tmo_q <= cfg_data[RUN_W-1:0];
			end
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (s_axis_tvalid && s_axis_tready) begin
					state_d = SQ_SCAN;
				end
			end
			SQ_SCAN: begin
				if (act_q == ACT_TICK) begin
					state_d = (used_q == '0) ? SQ_FINISH : SQ_TICK;
				end else if (act_q == ACT_REMOVE && slot_ok) begin
					state_d = SQ_SHIFT;
				end else if (idx_q >= used_q || (32'(idx_q) >= NUM_SLOTS) ||
					(ph_q != 2'd0 && hit_q)) begin
					state_d = SQ_FINISH;
				end
			end
			SQ_TICK: begin
				if (ph_q == 2'd3 && idx_q + 1'b1 >= used_q) begin
					state_d = SQ_FINISH;
				end
			end
			SQ_SHIFT: begin
				if (ph_q == 2'd1 && idx_q + 1'b1 >= used_q) begin
					state_d = SQ_FINISH;
				end
			end
			SQ_FINISH: state_d = (ph_q == 2'd3) ? SQ_OUT : SQ_FINISH;
			SQ_OUT: state_d = SQ_IDLE;
			default: state_d = SQ_IDLE;
		endcase
	end

	// Status and flags of the result.
	always_comb begin
		fin_res = '0;
		fin_res.status = ST_OK;
		unique case (act_q)
			ACT_ADD: begin
				if (used_q >= CW'(NUM_SLOTS)) begin
					fin_res.status = ST_FULL;
				end else if (hit_q) begin
					fin_res.status = ST_DUP;
					fin_res.found = 1'b1;
				end
			end
			ACT_REMOVE, ACT_SET_EN, ACT_SET_CREDIT, ACT_SET_LOCK, ACT_QUERY_SLOT: begin
				if (!slot_ok) begin
					fin_res.status = ST_INVALID;
				end
			end
			ACT_RX, ACT_TX, ACT_SEEN, ACT_QUERY_MAC: ;
			ACT_TICK: fin_res.tick_flags = flags_q;
			ACT_SET_RIDER: begin
				if (!(sl_q == 5'(NUM_SLOTS) || slot_ok)) begin
					fin_res.status = ST_INVALID;
				end
			end
			default: fin_res.status = ST_INVALID;
		endcase
	end

	// Memory access and datapath control.
	always_comb begin
		we = 1'b0;
		waddr = idx_q[IW-1:0];
		wrec = rrec;
		raddr = idx_q[IW-1:0];
		unique case (state_q)
			SQ_TICK: begin
				if (ph_q == 2'd3) begin
					we = 1'b1;
					wrec = tick_slot(rrec, kb, thr_q, tmo_q);
				end
			end
			SQ_SHIFT: begin
				raddr = IW'(idx_q + 1'b1);
				if (ph_q == 2'd1) begin
					we = 1'b1;
					if (idx_q + 1'b1 >= used_q) begin
						wrec = '0;
					end
				end
			end
			SQ_FINISH: begin
				raddr = hit_idx_q;
				waddr = hit_idx_q;
				if (ph_q == 2'd2 && hit_q) begin
					we = 1'b1;
					unique case (act_q)
						ACT_ADD: begin
							if (hit_idx_q == used_q[IW-1:0] && !res_q.found) begin
								wrec = '0;
								wrec.addr = mac_q;
								wrec.enabled = 1'b1;
							end
						end
						ACT_SET_EN: wrec.enabled = val_q[0];
						ACT_SET_CREDIT: wrec.credit = val_q;
						ACT_SET_LOCK: wrec.locked = val_q[0];
						ACT_RX: wrec.rx = rrec.rx + val_q;
						ACT_TX: wrec.tx = rrec.tx + val_q;
						ACT_SEEN: wrec.seen = 1'b1;
						default: we = 1'b0;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			used_q <= '0;
			rider_q <= 5'(NUM_SLOTS);
			ovalid_q <= 1'b0;
			idx_q <= '0;
			ph_q <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			flags_q <= '0;
			res_q <= '0;
		end else begin
			state_q <= state_d;
			if (ovalid_q && m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				SQ_IDLE: begin
					idx_q <= '0;
					ph_q <= '0;
					hit_q <= 1'b0;
					flags_q <= '0;
					hit_idx_q <= '0;
				end
				SQ_SCAN: begin
					if (state_d == SQ_SCAN) begin
						ph_q <= 2'd1;
						if (ph_q != 2'd0 && rrec.addr == mac_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= IW'(idx_q - 1'b1);
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						ph_q <= '0;
						if (act_q == ACT_REMOVE && slot_ok) begin
							idx_q <= CW'(sl_q);
						end else begin
							idx_q <= '0;
						end
						if (state_d == SQ_FINISH && !hit_q && ph_q != 2'd0 &&
							rrec.addr == mac_q && idx_q != '0 &&
							32'(idx_q - 1'b1) < NUM_SLOTS) begin
							hit_q <= 1'b1;
							hit_idx_q <= IW'(idx_q - 1'b1);
						end
					end
				end
				SQ_TICK: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd3) begin
						idx_q <= idx_q + 1'b1;
						if (wrec.credit != rrec.credit) begin
							flags_q[0] <= 1'b1;
							if (wrec.credit == '0) begin
								flags_q[1] <= 1'b1;
							end
						end
					end
				end
				SQ_SHIFT: begin
					if (ph_q == 2'd1) begin
						ph_q <= '0;
						idx_q <= idx_q + 1'b1;
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				SQ_FINISH: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd0) begin
						res_q <= fin_res;
						unique case (act_q)
							ACT_ADD: begin
								if (used_q >= CW'(NUM_SLOTS)) begin
									hit_q <= 1'b0;
								end else if (!hit_q) begin
									hit_q <= 1'b1;
									hit_idx_q <= used_q[IW-1:0];
								end
							end
							ACT_REMOVE, ACT_SET_EN, ACT_SET_CREDIT, ACT_SET_LOCK,
							ACT_QUERY_SLOT: begin
								if (!slot_ok) begin
									hit_q <= 1'b0;
								end else if (act_q == ACT_REMOVE) begin
									hit_q <= 1'b0;
									used_q <= used_q - 1'b1;
									if (rider_q == 5'(NUM_SLOTS)) begin
										rider_q <= rider_q;
									end else if (rider_q == sl_q) begin
										rider_q <= 5'(NUM_SLOTS);
									end else if (rider_q > sl_q) begin
										rider_q <= rider_q - 1'b1;
									end
								end else begin
									hit_q <= 1'b1;
									hit_idx_q <= IW'(sl_q);
								end
							end
							ACT_RX, ACT_TX, ACT_SEEN, ACT_QUERY_MAC, ACT_TICK: ;
							ACT_SET_RIDER: begin
								hit_q <= 1'b0;
								if (sl_q == 5'(NUM_SLOTS) || slot_ok) begin
									rider_q <= sl_q;
								end
							end
							default: hit_q <= 1'b0;
						endcase
					end else if (ph_q == 2'd2) begin
						if (act_q == ACT_ADD && hit_q && !res_q.found) begin
							used_q <= used_q + 1'b1;
						end
					end
				end
				SQ_OUT: begin
					res_q.entry_count <= 5'(used_q);
					res_q.rider_out <= rider_q;
					if (hit_q) begin
						res_q.found <= 1'b1;
						res_q.slot_out <= 4'(hit_idx_q);
						res_q.allowed <= rrec.enabled && rrec.credit != '0 && !rrec.locked;
						res_q.credit_out <= rrec.credit;
						res_q.throughput_out <= rrec.kbps;
						res_q.enabled_out <= rrec.enabled;
						res_q.paused_out <= rrec.paused;
						res_q.locked_out <= rrec.locked;
					end
					ovalid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			act_q <= s_axis_tdata[3:0];
			mac_q <= s_axis_tdata[51:4];
			sl_q <= s_axis_tdata[56:52];
			val_q <= s_axis_tdata[88:57];
		end
	end
endmodule

// ----- dv/tb_station_credit_traffic_gate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_station_credit_traffic_gate
// Drives station table commands into the gate, predicts each answer with an
// own model of the slot table, and compares every answer field by field.
// ----------------------------------------------------------------------------
module tb_station_credit_traffic_gate;
	import sctg_pkg::*;

	typedef struct packed {
		logic [1:0]  tick_flags;
		logic [4:0]  rider_out;
		logic [4:0]  entry_count;
		logic        locked_out;
		logic        paused_out;
		logic        enabled_out;
		logic [22:0] throughput_out;
		logic [31:0] credit_out;
		logic        allowed;
		logic [3:0]  slot_out;
		logic        found;
		logic [1:0]  status;
	} answer_t;

	class gate_scoreboard;
		logic [47:0] addr[16];
		logic        en[16];
		logic [31:0] cred[16];
		logic [31:0] rxa[16];
		logic [31:0] txa[16];
		logic [22:0] kb[16];
		logic [15:0] run[16];
		logic        pau[16];
		logic        lck[16];
		logic        sn[16];
		int          used;
		int          rider;
		logic [31:0] thr;
		logic [15:0] tmo;
		answer_t     pending[$];
		int          errors;

		function void clear_slot(int i);
			addr[i] = 0; en[i] = 0; cred[i] = 0; rxa[i] = 0; txa[i] = 0;
			kb[i] = 0; run[i] = 0; pau[i] = 0; lck[i] = 0; sn[i] = 0;
		endfunction

		function void reset_all();
			for (int i = 0; i < 16; i++) clear_slot(i);
			used = 0; rider = 16; thr = 0; tmo = 0; errors = 0;
		endfunction

		function int find(logic [47:0] a);
			for (int i = 0; i < used; i++) if (addr[i] == a) return i;
			return -1;
		endfunction

		function void note_item(logic [3:0] act, logic [47:0] mac, logic [4:0] sl,
			logic [31:0] val);
			answer_t r;
			int tgt;
			int f;
			logic [31:0] delta;
			logic [31:0] k;
			logic ok;
			r = '0;
			tgt = -1;
			ok = sl < used;
			case (act)
				ACT_ADD: begin
					if (used >= 16) r.status = ST_FULL;
					else begin
						f = find(mac);
						if (f >= 0) begin
							r.status = ST_DUP; tgt = f;
						end else begin
							clear_slot(used); addr[used] = mac; en[used] = 1;
							tgt = used; used++;
						end
					end
				end
				ACT_REMOVE: begin
					if (!ok) r.status = ST_INVALID;
					else begin
						for (int i = sl; i + 1 < used; i++) begin
							addr[i] = addr[i+1]; en[i] = en[i+1]; cred[i] = cred[i+1];
							rxa[i] = rxa[i+1]; txa[i] = txa[i+1]; kb[i] = kb[i+1];
							run[i] = run[i+1]; pau[i] = pau[i+1]; lck[i] = lck[i+1];
							sn[i] = sn[i+1];
						end
						used--; clear_slot(used);
						if (rider != 16) begin
							if (rider == sl) rider = 16;
							else if (rider > sl) rider--;
						end
					end
				end
				ACT_SET_EN, ACT_SET_CREDIT, ACT_SET_LOCK, ACT_QUERY_SLOT: begin
					if (!ok) r.status = ST_INVALID;
					else begin
						if (act == ACT_SET_EN) en[sl] = val[0];
						else if (act == ACT_SET_CREDIT) cred[sl] = val;
						else if (act == ACT_SET_LOCK) lck[sl] = val[0];
						tgt = sl;
					end
				end
				ACT_RX, ACT_TX, ACT_SEEN, ACT_QUERY_MAC: begin
					f = find(mac);
					if (f >= 0) begin
						if (act == ACT_RX) rxa[f] += val;
						else if (act == ACT_TX) txa[f] += val;
						else if (act == ACT_SEEN) sn[f] = 1;
						tgt = f;
					end
				end
				ACT_TICK: begin
					for (int i = 0; i < used; i++) begin
						delta = rxa[i] + txa[i];
						rxa[i] = 0; txa[i] = 0;
						if (!sn[i]) begin
							kb[i] = 0; run[i] = 0; pau[i] = 1;
						end else begin
							k = (delta * 32'd8) / 32'd1000;
							kb[i] = k[22:0];
							if (k > thr) begin
								run[i] = 0; pau[i] = 0;
							end else begin
								if (run[i] != 16'hFFFF) run[i]++;
								if (tmo == 0 || run[i] >= tmo) pau[i] = 1;
							end
							if (!pau[i] && en[i] && cred[i] != 0 && !lck[i]) begin
								cred[i]--;
								r.tick_flags[0] = 1;
								if (cred[i] == 0) r.tick_flags[1] = 1;
							end
						end
					end
					for (int i = 0; i < 16; i++) sn[i] = 0;
				end
				ACT_SET_RIDER: begin
					if (sl == 16 || ok) rider = sl;
					else r.status = ST_INVALID;
				end
				default: r.status = ST_INVALID;
			endcase
			if (tgt >= 0) begin
				r.found = 1;
				r.slot_out = tgt[3:0];
				r.allowed = en[tgt] && cred[tgt] != 0 && !lck[tgt];
				r.credit_out = cred[tgt];
				r.throughput_out = kb[tgt];
				r.enabled_out = en[tgt];
				r.paused_out = pau[tgt];
				r.locked_out = lck[tgt];
			end
			r.entry_count = used[4:0];
			r.rider_out = rider[4:0];
			pending.push_back(r);
		endfunction

		function void check_answer(answer_t got);
			answer_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat %h", $realtime, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				$display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [79:0] m_axis_tdata;
	logic        cfg_we = 0;
	logic        cfg_index = 0;
	logic [31:0] cfg_data = '0;

	int send_idle = 7;
	int recv_idle = 62;
	gate_scoreboard sb;
	logic [47:0] known_mac[$];

	station_credit_traffic_gate dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_answer(m_axis_tdata[77:0]);
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_item(logic [3:0] act, logic [47:0] mac, logic [4:0] sl,
		logic [31:0] val);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tdata <= {7'd0, val, sl, mac, act};
		s_axis_tvalid <= 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_item(act, mac, sl, val);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [31:0] d);
		drain();
		cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_THRESHOLD) sb.thr = d;
		else sb.tmo = d[15:0];
		@(posedge clk);
	endtask

	function automatic logic [47:0] rand_mac();
		if (known_mac.size() != 0 && $urandom_range(9) < 8)
			return known_mac[$urandom_range(known_mac.size() - 1)];
		return 48'({$urandom(), $urandom()});
	endfunction

	task automatic random_item();
		int p;
		logic [47:0] m;
		logic [31:0] v;
		p = $urandom_range(99);
		m = rand_mac();
		v = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(20000);
		if (p < 12) begin
			m = ($urandom_range(3) == 0) ? rand_mac() : 48'({$urandom(), $urandom()});
			known_mac.push_back(m);
			if (known_mac.size() > 40) void'(known_mac.pop_front());
			send_item(ACT_ADD, m, 0, 0);
		end else if (p < 18) send_item(ACT_REMOVE, 0, 5'($urandom_range(17)), 0);
		else if (p < 24) send_item(ACT_SET_EN, 0, 5'($urandom_range(17)), $urandom());
		else if (p < 31) send_item(ACT_SET_CREDIT, 0, 5'($urandom_range(17)),
			($urandom_range(1)) ? $urandom_range(4) : $urandom());
		else if (p < 35) send_item(ACT_SET_LOCK, 0, 5'($urandom_range(17)), $urandom());
		else if (p < 47) send_item(ACT_RX, m, 0, v);
		else if (p < 57) send_item(ACT_TX, m, 0, v);
		else if (p < 71) send_item(ACT_SEEN, m, 0, 0);
		else if (p < 80) send_item(ACT_TICK, 0, 0, 0);
		else if (p < 86) send_item(ACT_QUERY_MAC, m, 0, 0);
		else if (p < 91) send_item(ACT_QUERY_SLOT, 0, 5'($urandom_range(17)), 0);
		else if (p < 96) send_item(ACT_SET_RIDER, 0, 5'($urandom_range(17)), 0);
		else send_item(4'($urandom_range(15)), 48'({$urandom(), $urandom()}),
			5'($urandom()), $urandom());
	endtask

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		sb = new();
		sb.reset_all();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_cfg(CFG_THRESHOLD, 0);
		write_cfg(CFG_TIMEOUT, 0);
		send_item(ACT_QUERY_SLOT, 0, 0, 0);
		send_item(ACT_ADD, 48'hFFFF_FFFF_FFFF, 0, 0);
		send_item(ACT_ADD, 48'hFFFF_FFFF_FFFF, 0, 0);
		send_item(ACT_ADD, 48'h0, 0, 0);
		send_item(ACT_SET_CREDIT, 0, 0, 32'hFFFF_FFFF);
		send_item(ACT_SET_CREDIT, 0, 1, 1);
		send_item(ACT_SET_LOCK, 0, 1, 32'hFFFF_FFFF);
		send_item(ACT_SET_EN, 0, 1, 0);
		send_item(ACT_RX, 48'hFFFF_FFFF_FFFF, 0, 32'hFFFF_FFFF);
		send_item(ACT_TX, 48'hFFFF_FFFF_FFFF, 0, 32'hFFFF_FFFF);
		send_item(ACT_SEEN, 48'hFFFF_FFFF_FFFF, 0, 0);
		send_item(ACT_SEEN, 48'h1234, 0, 0);
		send_item(ACT_TICK, 0, 0, 0);
		send_item(ACT_QUERY_MAC, 48'hFFFF_FFFF_FFFF, 0, 0);
		send_item(ACT_SET_RIDER, 0, 1, 0);
		send_item(ACT_SET_RIDER, 0, 31, 0);
		send_item(ACT_REMOVE, 0, 0, 0);
		send_item(ACT_SET_RIDER, 0, 16, 0);
		send_item(ACT_REMOVE, 0, 31, 0);
		send_item(4'd15, 0, 0, 0);
		send_item(4'd12, 0, 0, 0);
		for (int i = 0; i < 17; i++) send_item(ACT_ADD, 48'h100 + i, 0, 0);
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_cfg(CFG_THRESHOLD, 32'hFFFF_FFFF); write_cfg(CFG_TIMEOUT, 16'hFFFF); end
				1: begin write_cfg(CFG_THRESHOLD, 40); write_cfg(CFG_TIMEOUT, 2); end
				2: begin send_idle = 62; recv_idle = 7; write_cfg(CFG_THRESHOLD, 5); end
				3: begin write_cfg(CFG_TIMEOUT, 0); write_cfg(CFG_THRESHOLD, 0); end
				4: begin send_idle = 0; recv_idle = 0; write_cfg(CFG_THRESHOLD, 100); write_cfg(CFG_TIMEOUT, 3); end
				default: write_cfg(CFG_THRESHOLD, $urandom());
			endcase
			for (int n = 0; n < 250; n++) random_item();
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
